[hw/rtl/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

[hw/rtl/lsharp_pkg.sv]
package lsharp_pkg;

  // field widths
  localparam int CHANNELS     = 3;
  localparam int PIX_W        = 8;
  localparam int COL_W        = 11;
  localparam int ROW_W        = 12;
  localparam int WIDTH_REG_W  = 12;
  localparam int HEIGHT_REG_W = 13;
  localparam int DIV_REG_W    = 8;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 13;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIVISOR      = 2'd2;

  // input word
  typedef struct packed {
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;
  } pixel_in_t;

  // output word
  typedef struct packed {
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;
    logic [COL_W-1:0] out_column;
    logic [ROW_W-1:0] out_row;
    logic             frame_done;
  } pixel_out_t;

endpackage

[hw/rtl/laplacian_sharpen_rgb_unit.sv]
// 3x3 laplacian sharpening of an rgb pixel stream in raster order.
// input channel: in_valid / in_stall with in_data; one pixel per word.
// output channel: out_valid / out_stall with out_data; one word for every
// interior pixel (border pixels give none), carrying its column and row and
// frame_done on the last interior pixel of the frame.
// config channel: cfg_valid / cfg_ready, cfg_index picks image_width (0),
// image_height (1) or divisor (2); write only while the block is idle.
// throughput: one pixel per cycle while the output word is not held. the two
// line stores sit in one 48-bit single-port-read memory read at acceptance
// and written back when the pixel leaves the first stage; the divide is an
// 11-stage restoring pipeline, one quotient bit per stage for all three
// channels. path: a pixel passes stage 1, the laplacian register, the divider
// stages and the output register before its result is on out_data.
// reset: counters and the window are cleared, registers take 640 x 480 and
// divisor 1; line store contents stay undefined, the first two rows of a
// frame fill them before they are used, so no clearing pass is run.
// stall: while the output word is held, the whole pipeline freezes and
// in_stall is high until the word is taken.
`include "assert_macros.svh"

module laplacian_sharpen_rgb_unit
  import lsharp_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pixel_in_t             in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output pixel_out_t            out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int LINE_W    = CHANNELS * PIX_W;
  localparam int MAG_W     = 11;
  localparam int DIV_STEPS = MAG_W;
  localparam logic [MAG_W-1:0] MAG_MAX = 11'd2040;

  typedef struct packed {
    logic                 neg;
    logic [DIV_REG_W-1:0] rem;
    logic [MAG_W-1:0]     nq;
    logic [PIX_W-1:0]     centre;
  } lane_t;

  typedef struct packed {
    lane_t [CHANNELS-1:0] lane;
    logic [COL_W-1:0]     col;
    logic [ROW_W-1:0]     row;
    logic                 done;
  } stage_t;

  // one restoring division step
  function automatic lane_t div_step(lane_t a, logic [DIV_REG_W-1:0] d);
    lane_t              r;
    logic [DIV_REG_W:0] t;
    logic               ge;
    r  = a;
    t  = {a.rem, a.nq[MAG_W-1]};
    ge = (t >= {1'b0, d});
    if (ge) begin
      r.rem = DIV_REG_W'(t - {1'b0, d});
    end else begin
      r.rem = t[DIV_REG_W-1:0];
    end
    r.nq = {a.nq[MAG_W-2:0], ge};
    return r;
  endfunction

  // byte of window row (0 top, 2 bottom) and channel
  function automatic logic [PIX_W-1:0] win_px(logic [3*LINE_W-1:0] w, int row, int k);
    return w[(2 - row) * LINE_W + PIX_W * k +: PIX_W];
  endfunction

  // configuration registers
  logic [WIDTH_REG_W-1:0]  image_width;
  logic [HEIGHT_REG_W-1:0] image_height;
  logic [DIV_REG_W-1:0]    divisor;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 12'd640;
      image_height <= 13'd480;
      divisor      <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_REG_W-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data[HEIGHT_REG_W-1:0];
        CFG_DIVISOR:      divisor      <= cfg_data[DIV_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry and divisor
  logic [CW-1:0]        w_last;
  logic [ROW_W-1:0]     h_last;
  logic [DIV_REG_W-1:0] d_eff;

  always_comb begin
    if (image_width < 12'd3) begin
      w_last = CW'(2);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_last = CW'(MAX_WIDTH - 1);
    end else begin
      w_last = CW'(image_width - 12'd1);
    end
    if (image_height < 13'd3) begin
      h_last = 12'd2;
    end else if (image_height > 13'd4096) begin
      h_last = 12'd4095;
    end else begin
      h_last = ROW_W'(image_height - 13'd1);
    end
    d_eff = (divisor == '0) ? 8'd1 : divisor;
  end

  // handshake
  logic adv;
  logic accept;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;
  assign accept   = in_valid && !in_stall;

  // position counters
  logic [CW-1:0]    col_count;
  logic [ROW_W-1:0] row_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (col_count >= w_last) begin
        col_count <= '0;
        row_count <= (row_count >= h_last) ? '0 : row_count + 12'd1;
      end else begin
        col_count <= col_count + CW'(1);
      end
    end
  end

  // line store memory: upper row in the high half, middle row in the low half
  logic [2*LINE_W-1:0] line_mem [MAX_WIDTH];
  logic [2*LINE_W-1:0] rd_q;
  logic                wr_en;

  // stage 1 registers
  logic               s1_valid;
  logic [LINE_W-1:0]  s1_pix;
  logic [CW-1:0]      s1_col;
  logic               s1_emit;
  logic               s1_done;
  logic [COL_W-1:0]   s1_ocol;
  logic [ROW_W-1:0]   s1_orow;

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_q <= line_mem[col_count];
    end
    if (wr_en) begin
      line_mem[s1_col] <= {rd_q[LINE_W-1:0], s1_pix};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix  <= {in_data.blue_in, in_data.green_in, in_data.red_in};
      s1_col  <= col_count;
      s1_emit <= (col_count >= CW'(2)) && (col_count <= w_last) &&
                 (row_count >= 12'd2) && (row_count <= h_last);
      s1_done <= (col_count == w_last) && (row_count == h_last);
      s1_ocol <= COL_W'(col_count - CW'(1));
      s1_orow <= row_count - 12'd1;
    end
  end

  assign wr_en = adv && s1_valid;

  // 3x3 window: two held columns plus the one arriving
  logic [3*LINE_W-1:0] win0;
  logic [3*LINE_W-1:0] win1;
  logic [3*LINE_W-1:0] col_w;

  assign col_w = {rd_q, s1_pix};

  always_ff @(posedge clk) begin
    if (rst) begin
      win0 <= '0;
      win1 <= '0;
    end else if (wr_en) begin
      win0 <= win1;
      win1 <= col_w;
    end
  end

  // laplacian per channel, sign and magnitude
  stage_t               dp [DIV_STEPS+1];
  stage_t               nx [DIV_STEPS];
  logic [DIV_STEPS:0]   dv;
  stage_t               lap_st;
  logic [MAG_W-1:0]     nb_sum [CHANNELS];
  logic [MAG_W-1:0]     c8     [CHANNELS];

  always_comb begin
    lap_st      = '0;
    lap_st.col  = s1_ocol;
    lap_st.row  = s1_orow;
    lap_st.done = s1_done;
    for (int k = 0; k < CHANNELS; k++) begin
      nb_sum[k] = MAG_W'(win_px(win0, 0, k)) + MAG_W'(win_px(win0, 1, k)) +
                  MAG_W'(win_px(win0, 2, k)) + MAG_W'(win_px(win1, 0, k)) +
                  MAG_W'(win_px(win1, 2, k)) + MAG_W'(win_px(col_w, 0, k)) +
                  MAG_W'(win_px(col_w, 1, k)) + MAG_W'(win_px(col_w, 2, k));
      c8[k] = {win_px(win1, 1, k), 3'b000};
      lap_st.lane[k].centre = win_px(win1, 1, k);
      lap_st.lane[k].rem    = '0;
      lap_st.lane[k].neg    = (c8[k] < nb_sum[k]);
      lap_st.lane[k].nq     = (c8[k] < nb_sum[k]) ? nb_sum[k] - c8[k] : c8[k] - nb_sum[k];
    end
  end

  // divider pipeline, one quotient bit per stage
  always_comb begin
    for (int g = 0; g < DIV_STEPS; g++) begin
      nx[g] = dp[g];
      for (int k = 0; k < CHANNELS; k++) begin
        nx[g].lane[k] = div_step(dp[g].lane[k], d_eff);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv <= '0;
    end else if (adv) begin
      dv <= {dv[DIV_STEPS-1:0], s1_valid && s1_emit};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dp[0] <= lap_st;
      for (int g = 0; g < DIV_STEPS; g++) begin
        dp[g+1] <= nx[g];
      end
    end
  end

  // add centre, clamp
  logic signed [12:0] sharp [CHANNELS];
  logic [PIX_W-1:0]   clamped [CHANNELS];

  always_comb begin
    for (int k = 0; k < CHANNELS; k++) begin
      if (dp[DIV_STEPS].lane[k].neg) begin
        sharp[k] = $signed({5'b0, dp[DIV_STEPS].lane[k].centre}) -
                   $signed({2'b0, dp[DIV_STEPS].lane[k].nq});
      end else begin
        sharp[k] = $signed({5'b0, dp[DIV_STEPS].lane[k].centre}) +
                   $signed({2'b0, dp[DIV_STEPS].lane[k].nq});
      end
      if (sharp[k] < 13'sd0) begin
        clamped[k] = 8'd0;
      end else if (sharp[k] > 13'sd255) begin
        clamped[k] = 8'd255;
      end else begin
        clamped[k] = sharp[k][PIX_W-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.red_out    <= clamped[0];
      out_data.green_out  <= clamped[1];
      out_data.blue_out   <= clamped[2];
      out_data.out_column <= dp[DIV_STEPS].col;
      out_data.out_row    <= dp[DIV_STEPS].row;
      out_data.frame_done <= dp[DIV_STEPS].done;
    end
  end

  // checks
  `ASSERT_IMP(a_no_rw_clash, clk, rst, accept && wr_en, col_count != s1_col)
  `ASSERT_NXT(a_accept_reaches_s1, clk, rst, accept, s1_valid)
  `ASSERT_IMP(a_quot_range, clk, rst, dv[DIV_STEPS], dp[DIV_STEPS].lane[0].nq <= MAG_MAX)

endmodule
